/* rtl/pnp_pkg.sv */
package pnp_pkg;

  // byte codes that drive the split
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  // queue sizes between the stages
  localparam int BQ_DEPTH = 4;
  localparam int BQ_PTR_W = $clog2(BQ_DEPTH);
  localparam int BQ_CNT_W = $clog2(BQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // result field widths
  localparam int OFF_W = 12;
  localparam int LEN_W = 13;
  localparam int DEP_W = 9;

  typedef enum logic [1:0] {
    EV_ROOT   = 2'd0,
    EV_NAME   = 2'd1,
    EV_PARENT = 2'd2,
    EV_FINAL  = 2'd3
  } ev_t;

  // class of the name being collected
  typedef enum logic [1:0] {
    DOT_OTHER = 2'd0,
    DOT_ONE   = 2'd1,
    DOT_TWO   = 2'd2
  } dcls_t;

  // classified input byte
  typedef struct packed {
    logic slash;
    logic dot;
    logic last;
  } beat_t;

  typedef struct packed {
    ev_t              ev;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic [DEP_W-1:0] depth;
    logic             valid_res;
    logic             normalized;
    logic             is_dir;
    logic [DEP_W-1:0] component_count;
    logic             end_of_run;
  } res_t;

  // up to two results written per processed byte, oldest in r0
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } oq_wr_t;

endpackage

/* rtl/path_normalize_parser_core.sv */
// Streaming path parser/normalizer.
// Input channel (in_*): one path byte per beat, in_last on the final byte;
// a beat is taken when in_push is high and in_full is low.
// Result channel (out_*): queue-style read side; a result sits on the
// out_ ports while out_empty is low and leaves on a cycle with out_pop high.
// Each byte yields zero, one or two results: an event for a root, kept
// name or kept parent step, and on the last byte a final status beat
// with out_end_of_run set.
// Data path: a taken byte is written into the byte queue, the back stage
// pops it and writes its results into the result queue, and the reader
// pops them from there.
// Throughput: one byte per cycle while in_full is low, limited by the
// result read side, which drains one beat per cycle; a byte with two
// results gives the reader an extra beat to pop.
// The front stage classifies bytes into a 4-deep queue; the back stage
// holds the path state and writes up to two results into a 4-deep result
// queue, and only takes a byte while two result slots are free.
// Reset (rst_n low, synchronous) empties both queues and starts a new path.
// A stalled reader backs up the result queue, then the byte queue, and
// finally raises in_full; nothing is dropped.
module path_normalize_parser_core
  import pnp_pkg::*;
#(
  parameter int MAX_PATH_LEN   = 4096,
  parameter int MAX_COMPONENTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [7:0]        in_char_in,
  input  logic              in_last,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [1:0]        out_event_res,
  output logic [OFF_W-1:0]  out_offset,
  output logic [LEN_W-1:0]  out_length,
  output logic [DEP_W-1:0]  out_depth,
  output logic              out_valid_res,
  output logic              out_normalized,
  output logic              out_is_dir,
  output logic [DEP_W-1:0]  out_component_count,
  output logic              out_end_of_run
);

  logic   bq_valid, bq_pop, oq_ready;
  beat_t  bq_beat;
  oq_wr_t oq_wr;
  res_t   head;

  // front: classify and queue bytes
  pnp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .char_in  (in_char_in),
    .last     (in_last),
    .full     (in_full),
    .bq_valid (bq_valid),
    .bq_beat  (bq_beat),
    .bq_pop   (bq_pop)
  );

  // back: path state, component and status events
  pnp_back #(
    .MAX_PATH_LEN   (MAX_PATH_LEN),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .bq_valid (bq_valid),
    .bq_beat  (bq_beat),
    .bq_pop   (bq_pop),
    .oq_ready (oq_ready),
    .oq_wr    (oq_wr)
  );

  // result queue, up to two writes and one read per cycle
  pnp_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (oq_wr),
    .ready (oq_ready),
    .empty (out_empty),
    .pop   (out_pop),
    .head  (head)
  );

  assign out_event_res       = head.ev;
  assign out_offset          = head.offset;
  assign out_length          = head.length;
  assign out_depth           = head.depth;
  assign out_valid_res       = head.valid_res;
  assign out_normalized      = head.normalized;
  assign out_is_dir          = head.is_dir;
  assign out_component_count = head.component_count;
  assign out_end_of_run      = head.end_of_run;

endmodule

/* rtl/pnp_front.sv */
module pnp_front
  import pnp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  logic  [7:0] char_in,
  input  logic  last,
  output logic  full,
  output logic  bq_valid,
  output beat_t bq_beat,
  input  logic  bq_pop
);

  beat_t                mem_r [BQ_DEPTH];
  logic [BQ_PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [BQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                 wr, rd;
  beat_t                cls;

  // classify the byte on entry
  always_comb begin
    cls.slash = (char_in == CHAR_SLASH);
    cls.dot   = (char_in == CHAR_DOT);
    cls.last  = last;
  end

  assign full     = (cnt_r == BQ_CNT_W'(BQ_DEPTH));
  assign bq_valid = (cnt_r != '0);
  assign bq_beat  = mem_r[rp_r];
  assign wr       = push & ~full;
  assign rd       = bq_pop & bq_valid;

  always_comb begin
    wp_nxt  = wr ? wp_r + BQ_PTR_W'(1) : wp_r;
    rp_nxt  = rd ? rp_r + BQ_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + BQ_CNT_W'(wr) - BQ_CNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= cls;
    end
  end

endmodule

/* rtl/pnp_back.sv */
module pnp_back
  import pnp_pkg::*;
#(
  parameter int MAX_PATH_LEN   = 4096,
  parameter int MAX_COMPONENTS = 256
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   bq_valid,
  input  beat_t  bq_beat,
  output logic   bq_pop,
  input  logic   oq_ready,
  output oq_wr_t oq_wr
);

  localparam int POS_W = $clog2(MAX_PATH_LEN + 1);
  localparam int CNT_W = $clog2(MAX_COMPONENTS + 1);
  localparam logic [POS_W-1:0] MAX_LEN_C = POS_W'(MAX_PATH_LEN);
  localparam logic [CNT_W-1:0] MAX_CMP_C = CNT_W'(MAX_COMPONENTS);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [POS_W-1:0] nlen_r, nlen_nxt;
  dcls_t            dcls_r, dcls_nxt;
  logic             rooted_r, rooted_nxt;
  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0] raw_r, raw_nxt;
  logic             norm_r, norm_nxt;
  logic             stop_r, stop_nxt;

  logic             take, stop0, act, root, fin_do, sep_name, dbl_slash;
  logic [POS_W-1:0] upd_start, upd_len, fin_start, fin_len;
  dcls_t            upd_cls, fin_cls;
  logic             f_emit, f_stop, f_nclr;
  ev_t              f_ev;
  logic [CNT_W-1:0] f_depth, f_raw;
  logic [CNT_W-1:0] depth_aft, raw_aft;
  logic             norm_aft, stop_aft, rooted_aft, ok_f, ev0;
  logic [POS_W-1:0] r0_start, r0_len;
  logic [CNT_W-1:0] r0_depth, fd, fc;
  logic [POS_W+OFF_W-1:0] off_x;
  logic [POS_W+LEN_W-1:0] len_x;
  logic [CNT_W+DEP_W-1:0] dep0_x, depf_x, cnt_x;
  res_t             r0, r1;

  assign take   = bq_valid & oq_ready;
  assign bq_pop = take;
  assign stop0  = stop_r | (pos_r >= MAX_LEN_C);
  assign act    = take & ~stop0;
  assign root      = act & bq_beat.slash & (pos_r == '0);
  assign sep_name  = act & bq_beat.slash & (pos_r != '0) & (nlen_r != '0);
  assign dbl_slash = act & bq_beat.slash & (pos_r != '0) & (nlen_r == '0);
  assign fin_do    = sep_name | (act & ~bq_beat.slash & bq_beat.last);

  // name bookkeeping for a non-slash byte
  always_comb begin
    upd_len = nlen_r + POS_W'(1);
    if (nlen_r == '0) begin
      upd_start = pos_r;
      upd_cls   = bq_beat.dot ? DOT_ONE : DOT_OTHER;
    end else begin
      upd_start = start_r;
      upd_cls   = (nlen_r == POS_W'(1) && dcls_r == DOT_ONE && bq_beat.dot) ?
                  DOT_TWO : DOT_OTHER;
    end
    fin_start = bq_beat.slash ? start_r : upd_start;
    fin_len   = bq_beat.slash ? nlen_r  : upd_len;
    fin_cls   = bq_beat.slash ? dcls_r  : upd_cls;
  end

  // closing a name
  always_comb begin
    f_emit  = 1'b0;
    f_stop  = 1'b0;
    f_nclr  = 1'b0;
    f_ev    = EV_NAME;
    f_depth = depth_r;
    f_raw   = raw_r;
    if (fin_cls == DOT_ONE) begin
      f_emit = 1'b0;
    end else if (raw_r >= MAX_CMP_C) begin
      f_stop = 1'b1;
    end else if (fin_cls == DOT_TWO) begin
      if (depth_r == '0) begin
        f_stop = 1'b1;
      end else if ((depth_r > CNT_W'(1) || !rooted_r) && depth_r == CNT_W'(1)) begin
        f_stop = 1'b1;
      end else begin
        if (depth_r > CNT_W'(1) || !rooted_r) begin
          f_depth = depth_r - CNT_W'(1);
        end
        f_raw  = raw_r + CNT_W'(1);
        f_nclr = 1'b1;
        f_emit = 1'b1;
        f_ev   = EV_PARENT;
      end
    end else begin
      f_raw   = raw_r + CNT_W'(1);
      f_depth = depth_r + CNT_W'(1);
      f_emit  = 1'b1;
    end
  end

  // state after the byte, then cleared on the last byte of a path
  always_comb begin
    rooted_aft = rooted_r | root;
    depth_aft  = depth_r;
    raw_aft    = raw_r;
    if (root) begin
      depth_aft = depth_r + CNT_W'(1);
      raw_aft   = raw_r + CNT_W'(1);
    end else if (fin_do) begin
      depth_aft = f_depth;
      raw_aft   = f_raw;
    end
    norm_aft = norm_r & ~root & ~dbl_slash & ~(fin_do & f_nclr);
    stop_aft = stop_r | (take & stop0) | (fin_do & f_stop);

    pos_nxt    = act ? pos_r + POS_W'(1) : pos_r;
    start_nxt  = start_r;
    nlen_nxt   = nlen_r;
    dcls_nxt   = dcls_r;
    if (act && bq_beat.slash) begin
      nlen_nxt = '0;
      dcls_nxt = DOT_OTHER;
    end else if (act) begin
      start_nxt = upd_start;
      nlen_nxt  = upd_len;
      dcls_nxt  = upd_cls;
    end
    rooted_nxt = rooted_aft;
    depth_nxt  = depth_aft;
    raw_nxt    = raw_aft;
    norm_nxt   = norm_aft;
    stop_nxt   = stop_aft;
    if (take && bq_beat.last) begin
      pos_nxt    = '0;
      start_nxt  = '0;
      nlen_nxt   = '0;
      dcls_nxt   = DOT_OTHER;
      rooted_nxt = 1'b0;
      depth_nxt  = '0;
      raw_nxt    = '0;
      norm_nxt   = 1'b1;
      stop_nxt   = 1'b0;
    end
  end

  // result beats
  always_comb begin
    ev0      = root | (fin_do & f_emit);
    r0_start = root ? '0 : fin_start;
    r0_len   = root ? POS_W'(1) : fin_len;
    r0_depth = root ? depth_r + CNT_W'(1) : f_depth;
    off_x    = {{OFF_W{1'b0}}, r0_start};
    len_x    = {{LEN_W{1'b0}}, r0_len};
    dep0_x   = {{DEP_W{1'b0}}, r0_depth};
    ok_f     = ~stop_aft & (raw_aft != '0);
    fd       = ok_f ? depth_aft : '0;
    fc       = ok_f ? raw_aft : '0;
    depf_x   = {{DEP_W{1'b0}}, fd};
    cnt_x    = {{DEP_W{1'b0}}, fc};

    r0.ev              = root ? EV_ROOT : f_ev;
    r0.offset          = off_x[OFF_W-1:0];
    r0.length          = len_x[LEN_W-1:0];
    r0.depth           = dep0_x[DEP_W-1:0];
    r0.valid_res       = 1'b0;
    r0.normalized      = 1'b0;
    r0.is_dir          = 1'b0;
    r0.component_count = '0;
    r0.end_of_run      = 1'b0;

    r1.ev              = EV_FINAL;
    r1.offset          = '0;
    r1.length          = '0;
    r1.depth           = depf_x[DEP_W-1:0];
    r1.valid_res       = ok_f;
    r1.normalized      = ok_f & norm_aft;
    r1.is_dir          = ok_f & bq_beat.slash;
    r1.component_count = cnt_x[DEP_W-1:0];
    r1.end_of_run      = 1'b1;

    if (ev0) begin
      oq_wr.r0 = r0;
      oq_wr.r1 = r1;
      oq_wr.n  = take ? (bq_beat.last ? 2'd2 : 2'd1) : 2'd0;
    end else begin
      oq_wr.r0 = r1;
      oq_wr.r1 = r1;
      oq_wr.n  = (take && bq_beat.last) ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      start_r  <= '0;
      nlen_r   <= '0;
      dcls_r   <= DOT_OTHER;
      rooted_r <= 1'b0;
      depth_r  <= '0;
      raw_r    <= '0;
      norm_r   <= 1'b1;
      stop_r   <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      nlen_r   <= nlen_nxt;
      dcls_r   <= dcls_nxt;
      rooted_r <= rooted_nxt;
      depth_r  <= depth_nxt;
      raw_r    <= raw_nxt;
      norm_r   <= norm_nxt;
      stop_r   <= stop_nxt;
    end
  end

  a_depth_le_raw: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= raw_r)
    else $error("normalized depth above raw component count");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && bq_beat.last) |=> (pos_r == '0 && raw_r == '0 && !stop_r))
    else $error("path state not cleared after last byte");

endmodule

/* rtl/pnp_outq.sv */
module pnp_outq
  import pnp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  oq_wr_t wr,
  output logic   ready,
  output logic   empty,
  input  logic   pop,
  output res_t   head
);

  res_t                mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [OQ_CNT_W-1:0] cnt_r, cnt_nxt, free;
  logic                rd;

  assign free  = OQ_CNT_W'(OQ_DEPTH) - cnt_r;
  assign ready = (free >= OQ_CNT_W'(2));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];
  assign rd    = pop & ~empty;

  always_comb begin
    wp_nxt  = wp_r + OQ_PTR_W'(wr.n);
    rp_nxt  = rd ? rp_r + OQ_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + OQ_CNT_W'(wr.n) - OQ_CNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.n != 2'd0) begin
      mem_r[wp_r] <= wr.r0;
    end
    if (wr.n == 2'd2) begin
      mem_r[wp_r + OQ_PTR_W'(1)] <= wr.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.n != 2'd0) |-> (OQ_CNT_W'(wr.n) <= free))
    else $error("result queue written beyond its free space");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue count out of range");

endmodule

/* tb/tb_top.sv */
module tb_top;
  import pnp_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int PATH_LIMIT   = 4096;
  localparam int COMP_LIMIT   = 256;
  // random stimulus volume, in bytes
  localparam int RAND_BYTES   = 160;
  // cycles to sit quiet after the last result; longer than a full reader
  // gap plus the block latency
  localparam int SETTLE_CYCLES = 12;
  // watchdog limit, in clock periods
  localparam int LIMIT_CYCLES = 150000;
  localparam int MAX_REPORTS  = 10;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_push;
  logic             in_full;
  logic [7:0]       in_char_in;
  logic             in_last;
  logic             out_empty;
  logic             out_pop;
  logic [1:0]       out_event_res;
  logic [OFF_W-1:0] out_offset;
  logic [LEN_W-1:0] out_length;
  logic [DEP_W-1:0] out_depth;
  logic             out_valid_res;
  logic             out_normalized;
  logic             out_is_dir;
  logic [DEP_W-1:0] out_component_count;
  logic             out_end_of_run;

  path_normalize_parser_core #(
    .MAX_PATH_LEN  (PATH_LIMIT),
    .MAX_COMPONENTS(COMP_LIMIT)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_char_in         (in_char_in),
    .in_last            (in_last),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_event_res      (out_event_res),
    .out_offset         (out_offset),
    .out_length         (out_length),
    .out_depth          (out_depth),
    .out_valid_res      (out_valid_res),
    .out_normalized     (out_normalized),
    .out_is_dir         (out_is_dir),
    .out_component_count(out_component_count),
    .out_end_of_run     (out_end_of_run)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Path state mirror. Updated once per accepted byte; the parse events it
  // produces are queued in order and the result checker consumes them.
  // ---------------------------------------------------------------------------
  int    path_pos;      // offset of the next byte in the current path
  int    name_off;      // offset where the pending name began
  int    name_len;      // bytes collected in the pending name
  dcls_t name_cls;      // ".", ".." or other
  bit    is_rooted;
  int    norm_depth;
  int    kept_count;    // raw components kept so far
  bit    still_norm;
  bit    halted;        // path already invalid, bytes ignored until last

  res_t  parse_events[$];

  int    fail_count;
  int    sent_bytes;
  int    send_gap_max;
  int    recv_gap_max;

  function automatic void clear_path();
    path_pos   = 0;
    name_off   = 0;
    name_len   = 0;
    name_cls   = DOT_OTHER;
    is_rooted  = 1'b0;
    norm_depth = 0;
    kept_count = 0;
    still_norm = 1'b1;
    halted     = 1'b0;
  endfunction

  function automatic void queue_event(ev_t ev, int off, int len, int dep, bit ok,
                                      bit nrm, bit dir, int cnt, bit eor);
    res_t r;
    r.ev              = ev;
    r.offset          = OFF_W'(off);
    r.length          = LEN_W'(len);
    r.depth           = DEP_W'(dep);
    r.valid_res       = ok;
    r.normalized      = nrm;
    r.is_dir          = dir;
    r.component_count = DEP_W'(cnt);
    r.end_of_run      = eor;
    parse_events.insert(parse_events.size(), r);
  endfunction

  // Close the pending name: "." vanishes, ".." pops (or is kept at a lone
  // root), anything else is a new level. Overflows and bad pops halt the path.
  function automatic void close_name();
    int    off;
    int    len;
    dcls_t cls;
    off      = name_off;
    len      = name_len;
    cls      = name_cls;
    name_len = 0;
    name_cls = DOT_OTHER;
    if (cls == DOT_ONE) return;
    if (kept_count >= COMP_LIMIT) begin
      halted = 1'b1;
      return;
    end
    if (cls == DOT_TWO) begin
      if (norm_depth == 0) begin
        halted = 1'b1;
        return;
      end
      if (norm_depth > 1 || !is_rooted) begin
        // popping the only level of a relative path is not allowed
        if (norm_depth == 1) begin
          halted = 1'b1;
          return;
        end
        norm_depth--;
      end
      kept_count++;
      still_norm = 1'b0;
      queue_event(EV_PARENT, off, len, norm_depth, 1'b0, 1'b0, 1'b0, 0, 1'b0);
      return;
    end
    kept_count++;
    norm_depth++;
    queue_event(EV_NAME, off, len, norm_depth, 1'b0, 1'b0, 1'b0, 0, 1'b0);
  endfunction

  function automatic void parse_byte(logic [7:0] c, logic lst);
    if (!halted && path_pos >= PATH_LIMIT) halted = 1'b1;
    if (!halted) begin
      if (c == CHAR_SLASH) begin
        if (path_pos == 0) begin
          is_rooted = 1'b1;
          kept_count++;
          norm_depth++;
          still_norm = 1'b0;
          queue_event(EV_ROOT, 0, 1, norm_depth, 1'b0, 1'b0, 1'b0, 0, 1'b0);
        end else if (name_len == 0) begin
          still_norm = 1'b0;  // repeated slash
        end else begin
          close_name();
        end
      end else begin
        if (name_len == 0) begin
          name_off = path_pos;
          if (c == CHAR_DOT) name_cls = DOT_ONE;
          else name_cls = DOT_OTHER;
        end else if (name_len == 1 && name_cls == DOT_ONE && c == CHAR_DOT) begin
          name_cls = DOT_TWO;
        end else begin
          name_cls = DOT_OTHER;
        end
        name_len++;
      end
      path_pos++;
    end
    if (lst) begin
      if (!halted && name_len > 0) close_name();
      if (!halted && kept_count > 0)
        queue_event(EV_FINAL, 0, 0, norm_depth, 1'b1, still_norm, c == CHAR_SLASH,
                    kept_count, 1'b1);
      else
        queue_event(EV_FINAL, 0, 0, 0, 1'b0, 1'b0, 1'b0, 0, 1'b1);
      clear_path();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every popped beat is compared against the oldest event.
  // ---------------------------------------------------------------------------
  function automatic string fmt_event(res_t r);
    return $sformatf("ev=%0d off=%0d len=%0d dep=%0d ok=%0b nrm=%0b dir=%0b cnt=%0d eor=%0b",
                     r.ev, r.offset, r.length, r.depth, r.valid_res, r.normalized,
                     r.is_dir, r.component_count, r.end_of_run);
  endfunction

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      got.ev              = ev_t'(out_event_res);
      got.offset          = out_offset;
      got.length          = out_length;
      got.depth           = out_depth;
      got.valid_res       = out_valid_res;
      got.normalized      = out_normalized;
      got.is_dir          = out_is_dir;
      got.component_count = out_component_count;
      got.end_of_run      = out_end_of_run;
      if (parse_events.size() == 0) begin
        log_failure({"unexpected beat: ", fmt_event(got)});
      end else begin
        want = parse_events.pop_front();
        if (got.ev !== want.ev || got.offset !== want.offset ||
            got.length !== want.length || got.depth !== want.depth ||
            got.valid_res !== want.valid_res || got.normalized !== want.normalized ||
            got.is_dir !== want.is_dir || got.component_count !== want.component_count ||
            got.end_of_run !== want.end_of_run)
          log_failure({"mismatch\n  exp: ", fmt_event(want), "\n  act: ", fmt_event(got)});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reader side: waits a random number of cycles before each pop.
  // ---------------------------------------------------------------------------
  initial begin : reader
    int gap;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, recv_gap_max);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. Called and returning at a falling edge; push stays high
  // into the next call so back-to-back bytes need no extra assignment.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic lst);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push    <= 1'b1;
    in_char_in <= c;
    in_last    <= lst;
    @(posedge clk);
    while (in_full) @(posedge clk);
    parse_byte(c, lst);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Stop sending and wait for every queued event to be popped, then for the
  // settle time, so a stray extra beat would still be caught.
  task automatic drain();
    in_push <= 1'b0;
    do @(negedge clk); while (parse_events.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-picked paths: root only, all event kinds, dot handling,
  // bad pops, nothing kept, repeated slashes and the byte extremes.
  task automatic test_directed();
    send_gap_max = 9;
    recv_gap_max = 9;
    send_text("/");        // lone root, trailing slash
    send_text("a/..");     // tries to pop the only level of a relative path
    send_text("/..");      // ".." at a lone root is kept without a pop
    send_text("/a/..");    // pop back down to the root
    send_text("../b");     // nothing to pop; rest of the path ignored
    send_text("./");       // nothing kept
    send_text("a//.");     // doubled slash, trailing dot dropped
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();
  endtask

  // One component past the limit: the last name halts the path, which
  // then reports invalid. The sender runs flat out here.
  task automatic test_component_limit();
    send_gap_max = 0;
    recv_gap_max = 3;
    for (int i = 0; i < COMP_LIMIT; i++) begin
      send_byte(8'h61, 1'b0);
      send_byte(CHAR_SLASH, 1'b0);
    end
    send_byte(8'h61, 1'b1);
    drain();
  endtask

  // One random path. Mostly well formed (names, ".", "..", doubled slashes,
  // optional root and trailing slash) so the depth actually grows and pops;
  // about one in ten is raw noise biased toward '/' and '.'.
  task automatic random_path();
    logic [7:0] seq[$];
    logic [7:0] b;
    int         parts;
    int         names;
    int         ups;
    int         kind;
    int         nlen;
    names = 0;
    ups   = 0;
    if ($urandom_range(0, 9) == 0) begin
      nlen = $urandom_range(1, 12);
      repeat (nlen) begin
        kind = $urandom_range(0, 3);
        if (kind == 0) seq.insert(seq.size(), CHAR_SLASH);
        else if (kind == 1) seq.insert(seq.size(), CHAR_DOT);
        else seq.insert(seq.size(), 8'($urandom_range(0, 255)));
      end
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        seq.insert(seq.size(), CHAR_SLASH);
        names = 1;
      end
      parts = $urandom_range(1, 7);
      for (int i = 0; i < parts; i++) begin
        kind = $urandom_range(0, 9);
        if (kind == 5) begin
          seq.insert(seq.size(), CHAR_DOT);
        end else if ((kind == 6 && names > ups + 1) ||
                     (kind == 7 && $urandom_range(0, 3) == 0)) begin
          // parent step; kind 7 may well be an illegal pop
          seq.insert(seq.size(), CHAR_DOT);
          seq.insert(seq.size(), CHAR_DOT);
          ups++;
        end else if (kind == 8) begin
          // empty component, gives a doubled slash
        end else if (kind == 9) begin
          // dot-led names; most are neither "." nor "..", but ".." can occur
          seq.insert(seq.size(), CHAR_DOT);
          if ($urandom_range(0, 1)) seq.insert(seq.size(), CHAR_DOT);
          seq.insert(seq.size(), $urandom_range(0, 1) ? CHAR_DOT : 8'h78);
          names++;
        end else begin
          nlen = $urandom_range(1, 6);
          repeat (nlen) begin
            if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
            else b = 8'($urandom_range(8'h61, 8'h7A));
            if (b == CHAR_SLASH) b = 8'h5F;
            seq.insert(seq.size(), b);
          end
          names++;
        end
        if (i < parts - 1 || $urandom_range(0, 1)) seq.insert(seq.size(), CHAR_SLASH);
      end
    end
    if (seq.size() == 0) seq.insert(seq.size(), 8'h61);
    for (int i = 0; i < seq.size(); i++) send_byte(seq[i], i == seq.size() - 1);
  endtask

  // Random paths in four phases, each with a different idling mix.
  // Every phase ends with a full drain, so the sender also waits out
  // all pending results at least once.
  task automatic test_random();
    int phase_start;
    for (int phase = 0; phase < 4; phase++) begin
      send_gap_max = (phase == 0 || phase == 2) ? 9 : 0;
      recv_gap_max = (phase == 0 || phase == 3) ? 9 : 0;
      phase_start  = sent_bytes;
      while (sent_bytes - phase_start < RAND_BYTES / 4) random_path();
      drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_char_in   = 8'h00;
    in_last      = 1'b0;
    fail_count   = 0;
    sent_bytes   = 0;
    send_gap_max = 0;
    recv_gap_max = 0;
    clear_path();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_component_limit();
    test_random();

    if (parse_events.size() != 0)
      log_failure($sformatf("%0d events never arrived", parse_events.size()));
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
rtl/pnp_pkg.sv
rtl/pnp_front.sv
rtl/pnp_back.sv
rtl/pnp_outq.sv
rtl/path_normalize_parser_core.sv
tb/tb_top.sv
